[rtl/core/dsh_pkg.sv]
package dsh_pkg;

    localparam int unsigned SAMPLE_W = 12;
    localparam int unsigned MEAN_W   = 20;
    localparam int unsigned STDEV_W  = 20;
    localparam int unsigned MEDIAN_W = 13;
    localparam int unsigned COUNT_W  = 17;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } t_in;

    typedef struct packed {
        logic [SAMPLE_W-1:0] minimum;
        logic [SAMPLE_W-1:0] maximum;
        logic [MEAN_W-1:0]   mean_fixed;
        logic [STDEV_W-1:0]  stdev_fixed;
        logic [SAMPLE_W-1:0] mode_value;
        logic [MEDIAN_W-1:0] median_doubled;
        logic [COUNT_W-1:0]  sample_count;
        logic                overflowed;
    } t_out;

    // top -> histogram unit
    typedef struct packed {
        logic upd;   // count one sample into its bin
        logic walk;  // start the end-of-set walk (read, evaluate, clear)
    } t_hist_ctl;

    // histogram unit -> top
    typedef struct packed {
        logic idle;  // not sweeping or walking
        logic done;  // walk finished, mode and median valid
    } t_hist_sts;

endpackage

[rtl/core/dsh_stream_if.sv]
interface dsh_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/descriptive_stats_histogram_top.sv]
// Descriptive statistics over a set of unsigned samples, histogram based.
// i_in carries one sample per transfer plus a last flag; o_out carries one
// result per set: min, max, mean and population stdev (fixed point), mode,
// doubled median, count and a dropped-samples flag.
// Samples are taken one per cycle; each bin update is a read-modify-write on
// the histogram RAM with forwarding between back-to-back hits on one bin.
// Samples past MAX_SAMPLES are not counted and set the overflow flag.
// After the last sample, a walk over all 2^SAMPLE_BITS bins finds mode and
// median and zeroes each bin; the multiply, square root and divide run
// bit-serially alongside it. Result timing is set by the bin walk.
// i_in.ready is low from the last sample until the result has been taken.
// The result is held in an output register until o_out.ready.
// After reset all 2^SAMPLE_BITS bins of the RAM are swept to zero, with
// i_in.ready low.
module descriptive_stats_histogram_top #(
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned MAX_SAMPLES = 65536,
    parameter int unsigned FRAC_BITS   = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dsh_stream_if.sink    i_in,
    dsh_stream_if.source  o_out
);
    localparam int unsigned SB     = SAMPLE_BITS;
    localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned SUM_W  = SB + CNT_W;
    localparam int unsigned SQ_W   = 2*SB + CNT_W;
    localparam int unsigned ROOT_W = (CNT_W + SQ_W + 2*FRAC_BITS + 1) / 2;
    localparam int unsigned DV_W   = (ROOT_W > SUM_W + FRAC_BITS) ? ROOT_W
                                                                  : (SUM_W + FRAC_BITS);

    localparam logic [1:0] T_RUN   = 2'd0;
    localparam logic [1:0] T_DRAIN = 2'd1;
    localparam logic [1:0] T_FIN   = 2'd2;
    localparam logic [1:0] T_OUT   = 2'd3;

    logic [1:0]       r_state;
    logic [SB-1:0]    r_min, r_max;
    logic [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]  r_sq;
    logic [CNT_W-1:0] r_cnt;
    logic             r_drop;
    logic             r_hdone, r_mdone;
    dsh_pkg::t_out    r_out;

    logic [SB-1:0]    w_s;
    logic             w_acc, w_full, w_upd;
    logic [2*SB-1:0]  w_sq;
    dsh_pkg::t_hist_ctl w_hctl;
    dsh_pkg::t_hist_sts w_hsts;
    logic [SB-1:0]    w_mode;
    logic [SB:0]      w_med2;
    logic             w_mdone;
    logic [DV_W-1:0]  w_mean, w_sd;
    logic             w_all;
    logic             w_nz;
    dsh_pkg::t_out    w_res;

    assign w_s    = SB'(i_in.data.sample);
    assign w_acc  = i_in.valid & i_in.ready;
    assign w_full = (r_cnt >= CNT_W'(MAX_SAMPLES));
    assign w_upd  = w_acc & ~w_full;
    assign w_sq   = w_s * w_s;

    assign i_in.ready = (r_state == T_RUN) & w_hsts.idle;

    assign w_hctl.upd  = w_upd;
    assign w_hctl.walk = (r_state == T_DRAIN);

    dsh_hist #(.SB(SB), .CNT_W(CNT_W)) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_hctl),
        .i_bin   (w_s),
        .i_n     (r_cnt),
        .o_sts   (w_hsts),
        .o_mode  (w_mode),
        .o_med2  (w_med2)
    );

    dsh_math #(.CNT_W(CNT_W), .SUM_W(SUM_W), .SQ_W(SQ_W), .FRAC(FRAC_BITS)) u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == T_DRAIN),
        .i_n     (r_cnt),
        .i_sum   (r_sum),
        .i_sq    (r_sq),
        .o_done  (w_mdone),
        .o_mean  (w_mean),
        .o_sd    (w_sd)
    );

    assign w_all = (r_hdone | w_hsts.done) & (r_mdone | w_mdone);
    assign w_nz  = (r_cnt != '0);

    always_comb begin
        w_res.minimum        = w_nz ? dsh_pkg::SAMPLE_W'(r_min) : '0;
        w_res.maximum        = dsh_pkg::SAMPLE_W'(r_max);
        w_res.mean_fixed     = !w_nz ? '0 : (|(w_mean >> dsh_pkg::MEAN_W)) ? '1
                             : dsh_pkg::MEAN_W'(w_mean);
        w_res.stdev_fixed    = !w_nz ? '0 : (|(w_sd >> dsh_pkg::STDEV_W)) ? '1
                             : dsh_pkg::STDEV_W'(w_sd);
        w_res.mode_value     = w_nz ? dsh_pkg::SAMPLE_W'(w_mode) : '0;
        w_res.median_doubled = w_nz ? dsh_pkg::MEDIAN_W'(w_med2) : '0;
        w_res.sample_count   = dsh_pkg::COUNT_W'(r_cnt);
        w_res.overflowed     = r_drop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_RUN;
            r_min   <= '1;
            r_max   <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_hdone <= 1'b0;
            r_mdone <= 1'b0;
        end else begin
            case (r_state)
                T_RUN: begin
                    if (w_acc) begin
                        if (w_full) begin
                            r_drop <= 1'b1;
                        end else begin
                            if (w_s < r_min) r_min <= w_s;
                            if (w_s > r_max) r_max <= w_s;
                            r_sum <= r_sum + SUM_W'(w_s);
                            r_sq  <= r_sq + SQ_W'(w_sq);
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        if (i_in.data.last) r_state <= T_DRAIN;
                    end
                end
                T_DRAIN: begin
                    r_hdone <= 1'b0;
                    r_mdone <= 1'b0;
                    r_state <= T_FIN;
                end
                T_FIN: begin
                    if (w_hsts.done) r_hdone <= 1'b1;
                    if (w_mdone)     r_mdone <= 1'b1;
                    if (w_all) begin
                        r_min   <= '1;
                        r_max   <= '0;
                        r_sum   <= '0;
                        r_sq    <= '0;
                        r_cnt   <= '0;
                        r_drop  <= 1'b0;
                        r_state <= T_OUT;
                    end
                end
                T_OUT: if (o_out.ready) r_state <= T_RUN;
                default: r_state <= T_RUN;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_FIN && w_all) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid = (r_state == T_OUT);
    assign o_out.data  = r_out;
endmodule

[rtl/core/dsh_ram.sv]
module dsh_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

[rtl/core/dsh_hist.sv]
module dsh_hist #(
    parameter int unsigned SB    = 12,
    parameter int unsigned CNT_W = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dsh_pkg::t_hist_ctl i_ctl,
    input  logic [SB-1:0]     i_bin,
    input  logic [CNT_W-1:0]  i_n,
    output dsh_pkg::t_hist_sts o_sts,
    output logic [SB-1:0]     o_mode,
    output logic [SB:0]       o_med2
);
    localparam logic [1:0] H_CLEAR = 2'd0;
    localparam logic [1:0] H_IDLE  = 2'd1;
    localparam logic [1:0] H_WALK  = 2'd2;
    localparam logic [1:0] H_TAIL  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [SB-1:0]    r_ptr;
    logic             r_done;

    // streaming read-modify-write stage
    logic             r_s1_v;
    logic [SB-1:0]    r_s1_addr;
    logic             r_fw_v;
    logic [SB-1:0]    r_fw_addr;
    logic [CNT_W-1:0] r_fw_data;

    // walk data stage
    logic             r_pv;
    logic [SB-1:0]    r_paddr;
    logic [CNT_W-1:0] r_cum;
    logic [CNT_W-1:0] r_best;
    logic [SB-1:0]    r_mode;
    logic [SB-1:0]    r_m1, r_m2;
    logic             r_f1, r_f2;

    logic             w_wr_en;
    logic [SB-1:0]    w_wr_addr;
    logic [CNT_W-1:0] w_wr_data;
    logic [SB-1:0]    w_rd_addr;
    logic [CNT_W-1:0] w_rd_data;
    logic [CNT_W-1:0] w_cur;
    logic [CNT_W-1:0] w_inc;
    logic [CNT_W-1:0] w_cum;
    logic [CNT_W-1:0] w_k1, w_k2;

    dsh_ram #(.WIDTH(CNT_W), .DEPTH(1 << SB)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // a bin read at the same edge as its previous write sees the old value
    assign w_cur = (r_fw_v && r_fw_addr == r_s1_addr) ? r_fw_data : w_rd_data;
    assign w_inc = w_cur + CNT_W'(1);
    assign w_cum = r_cum + w_rd_data;
    assign w_k1  = (i_n - CNT_W'(1)) >> 1;
    assign w_k2  = i_n >> 1;

    assign w_rd_addr = (r_state == H_WALK) ? r_ptr : i_bin;

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_s1_addr;
        w_wr_data = w_inc;
        if (r_state == H_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_ptr;
            w_wr_data = '0;
        end else if (r_pv) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_paddr;
            w_wr_data = '0;
        end else if (r_s1_v) begin
            w_wr_en   = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            H_CLEAR: if (r_ptr == '1) n_state = H_IDLE;
            H_IDLE:  if (i_ctl.walk) n_state = H_WALK;
            H_WALK:  if (r_ptr == '1) n_state = H_TAIL;
            H_TAIL:  n_state = H_IDLE;
            default: n_state = H_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_CLEAR;
            r_ptr   <= '0;
            r_s1_v  <= 1'b0;
            r_fw_v  <= 1'b0;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == H_CLEAR || r_state == H_WALK) begin
                r_ptr <= r_ptr + SB'(1);
            end else begin
                r_ptr <= '0;
            end
            r_s1_v <= i_ctl.upd;
            r_fw_v <= r_s1_v;
            r_pv   <= (r_state == H_WALK);
            r_done <= (r_state == H_TAIL);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_bin;
        r_fw_addr <= r_s1_addr;
        r_fw_data <= w_inc;
        r_paddr   <= r_ptr;
        if (r_state == H_IDLE) begin
            r_cum  <= '0;
            r_best <= '0;
            r_f1   <= 1'b0;
            r_f2   <= 1'b0;
            if (i_ctl.walk) begin
                r_mode <= '0;
                r_m1   <= '0;
                r_m2   <= '0;
            end
        end else if (r_pv) begin
            r_cum <= w_cum;
            if (w_rd_data > r_best) begin
                r_best <= w_rd_data;
                r_mode <= r_paddr;
            end
            if (!r_f1 && w_cum > w_k1) begin
                r_f1 <= 1'b1;
                r_m1 <= r_paddr;
            end
            if (!r_f2 && w_cum > w_k2) begin
                r_f2 <= 1'b1;
                r_m2 <= r_paddr;
            end
        end
    end

    assign o_sts.idle = (r_state == H_IDLE);
    assign o_sts.done = r_done;
    assign o_mode     = r_mode;
    assign o_med2     = {1'b0, r_m1} + {1'b0, r_m2};
endmodule

[rtl/core/dsh_math.sv]
module dsh_math #(
    parameter int unsigned CNT_W = 17,
    parameter int unsigned SUM_W = 29,
    parameter int unsigned SQ_W  = 41,
    parameter int unsigned FRAC  = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [CNT_W-1:0]     i_n,
    input  logic [SUM_W-1:0]     i_sum,
    input  logic [SQ_W-1:0]      i_sq,
    output logic                 o_done,
    output logic [(((CNT_W+SQ_W+2*FRAC+1)/2) > (SUM_W+FRAC)
                   ? ((CNT_W+SQ_W+2*FRAC+1)/2) : (SUM_W+FRAC))-1:0] o_mean,
    output logic [(((CNT_W+SQ_W+2*FRAC+1)/2) > (SUM_W+FRAC)
                   ? ((CNT_W+SQ_W+2*FRAC+1)/2) : (SUM_W+FRAC))-1:0] o_sd
);
    localparam int unsigned D_W    = CNT_W + SQ_W;
    localparam int unsigned ROOT_W = (D_W + 2*FRAC + 1) / 2;
    localparam int unsigned X_W    = 2 * ROOT_W;
    localparam int unsigned RM_W   = ROOT_W + 2;
    localparam int unsigned DV_W   = (ROOT_W > SUM_W + FRAC) ? ROOT_W : (SUM_W + FRAC);
    localparam int unsigned STEP_W = $clog2(DV_W + SUM_W + 1);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_MUL1 = 3'd1;
    localparam logic [2:0] M_MUL2 = 3'd2;
    localparam logic [2:0] M_SQRT = 3'd3;
    localparam logic [2:0] M_DIV1 = 3'd4;
    localparam logic [2:0] M_DIV2 = 3'd5;

    logic [2:0]        r_state;
    logic [STEP_W-1:0] r_step;
    logic [D_W-1:0]    r_acc, r_mcand;
    logic [SUM_W-1:0]  r_mplier;
    logic [X_W-1:0]    r_x;
    logic [RM_W-1:0]   r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W:0]    r_drem;
    logic [DV_W-1:0]   r_dvd;
    logic [DV_W-1:0]   r_mean, r_sd;
    logic              r_done;

    logic [D_W-1:0]    w_add, w_sub;
    logic [RM_W-1:0]   w_trem, w_trial;
    logic              w_sq_ge;
    logic [CNT_W:0]    w_t, w_nx;
    logic              w_dv_ge;
    logic [DV_W-1:0]   w_q;

    assign w_add = r_mplier[0] ? r_acc + r_mcand : r_acc;
    assign w_sub = r_mplier[0] ? r_acc - r_mcand : r_acc;

    // one root bit per step from the next pair of radicand bits
    assign w_trem  = {r_rem[RM_W-3:0], r_x[X_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_sq_ge = (w_trem >= w_trial);

    // restoring division, quotient shifts into the dividend register
    assign w_t     = {r_drem[CNT_W-1:0], r_dvd[DV_W-1]};
    assign w_nx    = {1'b0, i_n};
    assign w_dv_ge = (w_t >= w_nx);
    assign w_q     = {r_dvd[DV_W-2:0], w_dv_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                M_IDLE: if (i_start) r_state <= M_MUL1;
                M_MUL1: if (r_step == STEP_W'(CNT_W-1)) r_state <= M_MUL2;
                M_MUL2: if (r_step == STEP_W'(SUM_W-1)) r_state <= M_SQRT;
                M_SQRT: if (r_step == STEP_W'(ROOT_W-1)) r_state <= M_DIV1;
                M_DIV1: if (r_step == STEP_W'(DV_W-1)) r_state <= M_DIV2;
                M_DIV2: begin
                    if (r_step == STEP_W'(DV_W-1)) begin
                        r_state <= M_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= r_step + STEP_W'(1);
        case (r_state)
            M_IDLE: begin
                r_step   <= '0;
                r_acc    <= '0;
                r_mcand  <= D_W'(i_sq);
                r_mplier <= SUM_W'(i_n);
            end
            M_MUL1: begin
                r_acc    <= w_add;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                if (r_step == STEP_W'(CNT_W-1)) begin
                    r_step   <= '0;
                    r_mcand  <= D_W'(i_sum);
                    r_mplier <= i_sum;
                end
            end
            M_MUL2: begin
                r_acc    <= w_sub;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                if (r_step == STEP_W'(SUM_W-1)) begin
                    r_step <= '0;
                    r_x    <= X_W'(w_sub) << (2*FRAC);
                    r_rem  <= '0;
                    r_root <= '0;
                end
            end
            M_SQRT: begin
                r_x    <= r_x << 2;
                r_rem  <= w_sq_ge ? w_trem - w_trial : w_trem;
                r_root <= {r_root[ROOT_W-2:0], w_sq_ge};
                if (r_step == STEP_W'(ROOT_W-1)) begin
                    r_step <= '0;
                    r_drem <= '0;
                    r_dvd  <= DV_W'({r_root[ROOT_W-2:0], w_sq_ge});
                end
            end
            M_DIV1: begin
                r_drem <= w_dv_ge ? w_t - w_nx : w_t;
                r_dvd  <= w_q;
                if (r_step == STEP_W'(DV_W-1)) begin
                    r_step <= '0;
                    r_sd   <= w_q;
                    r_drem <= '0;
                    r_dvd  <= DV_W'(i_sum) << FRAC;
                end
            end
            M_DIV2: begin
                r_drem <= w_dv_ge ? w_t - w_nx : w_t;
                r_dvd  <= w_q;
                if (r_step == STEP_W'(DV_W-1)) begin
                    r_mean <= w_q;
                end
            end
            default: r_step <= '0;
        endcase
    end

    assign o_done = r_done;
    assign o_mean = r_mean;
    assign o_sd   = r_sd;
endmodule
